// ===== hdl/tld_pkg.sv =====
// tld_pkg: shared types, codes and constants of the terminal line discipline.
// Used by tld_line_ram and terminal_line_discipline_core; depends on nothing.

package tld_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int MAX_READ   = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int FILL_W     = ADDR_W + 1;
  localparam int RD_W       = $clog2(MAX_READ + 1);
  localparam int SEQ_MAX    = 6;
  localparam int SEQ_W      = $clog2(SEQ_MAX + 1);

  // input modes
  localparam logic [1:0] MODE_RX   = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DISPLAY   = 2'd0;
  localparam logic [1:0] KIND_READ      = 2'd1;
  localparam logic [1:0] KIND_NOT_READY = 2'd2;

  // config register indexes
  localparam logic [2:0] CFG_TERM_FLAGS = 3'd0;
  localparam logic [2:0] CFG_EOF_CHAR   = 3'd1;
  localparam logic [2:0] CFG_EOL_CHAR   = 3'd2;
  localparam logic [2:0] CFG_ERASE_CHAR = 3'd3;
  localparam logic [2:0] CFG_INTR_CHAR  = 3'd4;
  localparam logic [2:0] CFG_FG_PRESENT = 3'd5;

  // term_flags bits
  localparam int FLAG_CANON = 0;
  localparam int FLAG_ECHO  = 1;
  localparam int FLAG_SIG   = 2;
  localparam int FLAG_ONLCR = 3;

  // register reset values
  localparam logic [3:0] TERM_FLAGS_RST = 4'd15;
  localparam logic [7:0] EOF_RST        = 8'd4;
  localparam logic [7:0] EOL_RST        = 8'd10;
  localparam logic [7:0] ERASE_RST      = 8'o177;
  localparam logic [7:0] INTR_RST       = 8'd3;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C     = 8'h43;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ
  } tld_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [6:0] read_count;
  } tld_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       interrupt_raised;
    logic       last;
  } tld_result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } tld_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tld_rd_t;

endpackage

// ===== hdl/tld_line_ram.sv =====
// tld_line_ram: line store, one write port and one registered read port.
// Depends on tld_pkg.

module tld_line_ram (
  input  logic             clk,
  input  tld_pkg::tld_wr_t wr,
  input  tld_pkg::tld_rd_t rd,
  output logic [7:0]       rdata
);

  logic [7:0] mem [tld_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== hdl/terminal_line_discipline_core.sv =====
// terminal_line_discipline_core: canonical terminal input discipline, top level.
// Depends on tld_pkg and tld_line_ram.

// Usage: an item is taken when start is high and busy is low. Each result is
// shown on result for exactly one cycle with result_valid high; the receiver
// cannot stall, so it must take every strobed item. A received character or
// output byte gives up to six results (six for the erase sequence), one per
// cycle; busy drops right after the result marked last. A read of n bytes
// does one line store read per cycle, and each byte comes out in the cycle
// after its read because the store's read port is registered. A read that
// finds the store empty, or no finished line in canonical mode, gives one
// not-ready result. Items that cause no result (end-of-file, erase on an
// empty line, a zero-length read, mode 3) leave busy low. The 256-byte line
// store needs no clearing after reset: only bytes counted in the fill level
// are read. Configuration writes are always accepted (cfg_ready stays high)
// and must be made only while the block is idle.

module terminal_line_discipline_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tld_pkg::tld_item_t   item,
  output logic                 result_valid,
  output tld_pkg::tld_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  // configuration registers
  logic [3:0] term_flags;
  logic [7:0] eof_char;
  logic [7:0] eol_char;
  logic [7:0] erase_char;
  logic [7:0] intr_char;
  logic       fg_present;

  // control state
  tld_pkg::tld_state_t          state, state_next;
  logic [tld_pkg::ADDR_W-1:0]   oldest, oldest_next;
  logic [tld_pkg::FILL_W-1:0]   fill, fill_next;
  logic                         line_ready, line_ready_next;
  logic [tld_pkg::SEQ_W-1:0]    seq_len, seq_len_next;
  logic [tld_pkg::SEQ_W-1:0]    seq_idx, seq_idx_next;
  logic [tld_pkg::RD_W-1:0]     rd_left, rd_left_next;
  logic                         rd_pend, rd_pend_next;
  logic                         rd_last, rd_last_next;

  // sequence payload
  logic [7:0] seq_bytes [tld_pkg::SEQ_MAX];
  logic [7:0] seq_bytes_next [tld_pkg::SEQ_MAX];
  logic [1:0] seq_kind, seq_kind_next;
  logic       seq_intr, seq_intr_next;

  // line store ports
  tld_pkg::tld_wr_t ram_wr;
  tld_pkg::tld_rd_t ram_rd;
  logic [7:0]       ram_rdata;

  logic                       accept;
  logic                       canon, echo_on, sig_on, onlcr;
  logic [7:0]                 c;
  logic                       is_intr;
  logic                       char_is_nl;
  logic [tld_pkg::RD_W-1:0]   cnt_cap;
  logic [tld_pkg::RD_W-1:0]   rd_n;

  assign cfg_ready = 1'b1;
  assign busy      = (state != tld_pkg::ST_IDLE) | rd_pend;
  assign accept    = start & ~busy;

  assign canon   = term_flags[tld_pkg::FLAG_CANON];
  assign echo_on = term_flags[tld_pkg::FLAG_ECHO];
  assign sig_on  = term_flags[tld_pkg::FLAG_SIG];
  assign onlcr   = term_flags[tld_pkg::FLAG_ONLCR];

  assign c          = item.data_byte;
  assign is_intr    = (c == intr_char) & fg_present & sig_on;
  assign char_is_nl = onlcr & (c == tld_pkg::CH_LF);

  // read length: count capped at MAX_READ, then at the fill level
  assign cnt_cap = (item.read_count > 7'(tld_pkg::MAX_READ)) ?
                   tld_pkg::RD_W'(tld_pkg::MAX_READ) : tld_pkg::RD_W'(item.read_count);
  assign rd_n    = (fill < tld_pkg::FILL_W'(cnt_cap)) ? tld_pkg::RD_W'(fill) : cnt_cap;

  tld_line_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      term_flags <= tld_pkg::TERM_FLAGS_RST;
      eof_char   <= tld_pkg::EOF_RST;
      eol_char   <= tld_pkg::EOL_RST;
      erase_char <= tld_pkg::ERASE_RST;
      intr_char  <= tld_pkg::INTR_RST;
      fg_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tld_pkg::CFG_TERM_FLAGS: term_flags <= cfg_data[3:0];
        tld_pkg::CFG_EOF_CHAR:   eof_char   <= cfg_data;
        tld_pkg::CFG_EOL_CHAR:   eol_char   <= cfg_data;
        tld_pkg::CFG_ERASE_CHAR: erase_char <= cfg_data;
        tld_pkg::CFG_INTR_CHAR:  intr_char  <= cfg_data;
        tld_pkg::CFG_FG_PRESENT: fg_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state: accept decode, display sequence, read sweep
  always_comb begin
    logic do_store;
    logic do_echo;

    state_next      = state;
    oldest_next     = oldest;
    fill_next       = fill;
    line_ready_next = line_ready;
    seq_len_next    = seq_len;
    seq_idx_next    = seq_idx;
    seq_kind_next   = seq_kind;
    seq_intr_next   = seq_intr;
    rd_left_next    = rd_left;
    rd_pend_next    = 1'b0;
    rd_last_next    = rd_last;
    for (int i = 0; i < tld_pkg::SEQ_MAX; i++) begin
      seq_bytes_next[i] = seq_bytes[i];
    end
    ram_wr   = '0;
    ram_rd   = '0;
    do_store = 1'b0;
    do_echo  = 1'b0;

    case (state)
      tld_pkg::ST_IDLE: begin
        if (accept) begin
          seq_len_next  = '0;
          seq_idx_next  = '0;
          seq_kind_next = tld_pkg::KIND_DISPLAY;
          seq_intr_next = 1'b0;
          case (item.mode)
            tld_pkg::MODE_RX: begin
              if (is_intr) begin
                // "^C" plus newline, newline translated if enabled
                seq_intr_next     = 1'b1;
                seq_bytes_next[0] = tld_pkg::CH_CARET;
                seq_bytes_next[1] = tld_pkg::CH_C;
                if (onlcr) begin
                  seq_bytes_next[2] = tld_pkg::CH_CR;
                  seq_bytes_next[3] = tld_pkg::CH_LF;
                  seq_len_next      = tld_pkg::SEQ_W'(4);
                end else begin
                  seq_bytes_next[2] = tld_pkg::CH_LF;
                  seq_len_next      = tld_pkg::SEQ_W'(3);
                end
              end else if (canon) begin
                if (c == eof_char) begin
                  line_ready_next = 1'b1;
                end else begin
                  if (c == eol_char) begin
                    line_ready_next = 1'b1;
                  end
                  if (c == erase_char) begin
                    if (fill != '0) begin
                      seq_bytes_next[0] = tld_pkg::CH_ESC;
                      seq_bytes_next[1] = tld_pkg::CH_LBRK;
                      seq_bytes_next[2] = tld_pkg::CH_D;
                      seq_bytes_next[3] = tld_pkg::CH_ESC;
                      seq_bytes_next[4] = tld_pkg::CH_LBRK;
                      seq_bytes_next[5] = tld_pkg::CH_K;
                      seq_len_next      = tld_pkg::SEQ_W'(6);
                      fill_next         = fill - 1'b1;
                    end
                  end else begin
                    do_store = 1'b1;
                    do_echo  = echo_on;
                  end
                end
              end else begin
                do_store = 1'b1;
                do_echo  = echo_on;
              end
            end
            tld_pkg::MODE_TX: begin
              do_echo = 1'b1;
            end
            tld_pkg::MODE_READ: begin
              if ((fill == '0) || (canon && !line_ready)) begin
                seq_kind_next     = tld_pkg::KIND_NOT_READY;
                seq_bytes_next[0] = 8'h00;
                seq_len_next      = tld_pkg::SEQ_W'(1);
              end else begin
                if (canon) begin
                  line_ready_next = 1'b0;
                end
                if (rd_n != '0) begin
                  rd_left_next = rd_n;
                  state_next   = tld_pkg::ST_READ;
                end
              end
            end
            default: ;
          endcase

          // full store drops the byte; store then echo order is invisible here
          if (do_store && !fill[tld_pkg::FILL_W-1]) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = oldest + fill[tld_pkg::ADDR_W-1:0];
            ram_wr.data = c;
            fill_next   = fill + 1'b1;
          end
          if (do_echo) begin
            if (char_is_nl) begin
              seq_bytes_next[0] = tld_pkg::CH_CR;
              seq_bytes_next[1] = tld_pkg::CH_LF;
              seq_len_next      = tld_pkg::SEQ_W'(2);
            end else begin
              seq_bytes_next[0] = c;
              seq_len_next      = tld_pkg::SEQ_W'(1);
            end
          end
          if (seq_len_next != '0) begin
            state_next = tld_pkg::ST_EMIT;
          end
        end
      end
      tld_pkg::ST_EMIT: begin
        seq_idx_next = seq_idx + 1'b1;
        if (seq_idx == seq_len - 1'b1) begin
          state_next = tld_pkg::ST_IDLE;
        end
      end
      tld_pkg::ST_READ: begin
        // one pop a cycle; data returns from the store's registered read port in the next cycle
        ram_rd.en    = 1'b1;
        ram_rd.addr  = oldest;
        oldest_next  = oldest + 1'b1;
        fill_next    = fill - 1'b1;
        rd_left_next = rd_left - 1'b1;
        rd_pend_next = 1'b1;
        rd_last_next = (rd_left == tld_pkg::RD_W'(1));
        if (rd_left == tld_pkg::RD_W'(1)) begin
          state_next = tld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tld_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tld_pkg::ST_IDLE;
      oldest     <= '0;
      fill       <= '0;
      line_ready <= 1'b0;
      seq_len    <= '0;
      seq_idx    <= '0;
      rd_left    <= '0;
      rd_pend    <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      state      <= state_next;
      oldest     <= oldest_next;
      fill       <= fill_next;
      line_ready <= line_ready_next;
      seq_len    <= seq_len_next;
      seq_idx    <= seq_idx_next;
      rd_left    <= rd_left_next;
      rd_pend    <= rd_pend_next;
      rd_last    <= rd_last_next;
    end
  end

  // sequence payload, no reset
  always_ff @(posedge clk) begin
    seq_kind <= seq_kind_next;
    seq_intr <= seq_intr_next;
    for (int i = 0; i < tld_pkg::SEQ_MAX; i++) begin
      seq_bytes[i] <= seq_bytes_next[i];
    end
  end

  // result port: read data straight from the store's output register,
  // otherwise the current byte of the display sequence
  assign result_valid = (state == tld_pkg::ST_EMIT) | rd_pend;

  always_comb begin
    if (rd_pend) begin
      result.result_kind      = tld_pkg::KIND_READ;
      result.out_byte         = ram_rdata;
      result.interrupt_raised = 1'b0;
      result.last             = rd_last;
    end else begin
      result.result_kind      = seq_kind;
      result.out_byte         = seq_bytes[seq_idx];
      result.interrupt_raised = seq_intr;
      result.last             = (seq_idx == seq_len - 1'b1);
    end
  end

endmodule
